@@ hdl/smd_pkg.sv @@
// Types and constants shared by the stream message deframer modules.
`default_nettype none

package smd_pkg;

   localparam logic [7:0]  ESC_BYTE       = 8'hFF;
   localparam logic [15:0] MAX_BYTES_INIT = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ESCAPE,
      PH_QUOTE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_END,
      KIND_OVERFLOW
   } kind_type;

   typedef struct packed {
      logic        discard;
      phase_type   phase;
      logic [7:0]  quote_left;
      logic [15:0] message_bytes;
   } state_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [15:0] message_length;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/smd_update.sv @@
// Per-stream delimiting decode: next stream state and the result of one byte.
`default_nettype none

module smd_update
   import smd_pkg::*;
(
   input  state_type   cur_state,
   input  logic [7:0]  data_byte,
   input  logic [15:0] max_bytes,
   output state_type   nxt_state,
   output result_type  result
);

   logic       emit_req;
   logic [7:0] emit_byte;
   logic       end_mark;
   logic       over;

   always_comb begin
      emit_req  = 1'b0;
      emit_byte = data_byte;
      end_mark  = 1'b0;
      case (cur_state.phase)
         PH_QUOTE: begin
            emit_req = 1'b1;
         end
         PH_ESCAPE: begin
            if (data_byte == ESC_BYTE) begin
               end_mark = 1'b1;
            end else begin
               emit_req  = 1'b1;
               emit_byte = ESC_BYTE;
            end
         end
         default: begin
            emit_req = (data_byte != ESC_BYTE);
         end
      endcase
      over = emit_req && !cur_state.discard && (cur_state.message_bytes >= max_bytes);
   end

   always_comb begin
      nxt_state = cur_state;
      case (cur_state.phase)
         PH_QUOTE: begin
            nxt_state.quote_left = cur_state.quote_left - 8'd1;
            if (nxt_state.quote_left == 8'd0) begin
               nxt_state.phase = PH_NORMAL;
            end
         end
         PH_ESCAPE: begin
            if (end_mark) begin
               nxt_state.phase         = PH_NORMAL;
               nxt_state.message_bytes = '0;
               nxt_state.discard       = 1'b0;
            end else begin
               nxt_state.quote_left = data_byte;
               nxt_state.phase      = (data_byte != 8'd0) ? PH_QUOTE : PH_NORMAL;
            end
         end
         default: begin
            nxt_state.phase = (data_byte == ESC_BYTE) ? PH_ESCAPE : PH_NORMAL;
         end
      endcase
      if (emit_req && !cur_state.discard) begin
         if (over) begin
            nxt_state.discard       = 1'b1;
            nxt_state.message_bytes = '0;
         end else begin
            nxt_state.message_bytes = cur_state.message_bytes + 16'd1;
         end
      end
   end

   always_comb begin
      result = '0;
      if (emit_req && !cur_state.discard) begin
         result.valid = 1'b1;
         if (over) begin
            result.kind = KIND_OVERFLOW;
         end else begin
            result.kind     = KIND_DATA;
            result.out_byte = emit_byte;
         end
      end else if (end_mark && !cur_state.discard && (cur_state.message_bytes != 16'd0)) begin
         result.valid          = 1'b1;
         result.kind           = KIND_END;
         result.message_length = cur_state.message_bytes;
      end
   end

endmodule

`default_nettype wire

@@ hdl/stream_message_deframer.sv @@
// Top level of the stream message deframer: per-stream state memory and result register.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tdata: stream, data_byte
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: out_stream, out_byte, message_length;
//                                               tuser: kind
//   csr_      in         csr_valid/csr_ready    max_message_bytes
//
// One byte per cycle sustained unless the output stalls; each byte reads its stream state
// at the accepting edge and is decoded in the next cycle, and its result is written into
// the output register when the decode stage advances.
// A write-back to the same stream as the byte being read is forwarded into the read data.
// Reset clears the per-stream valid bits, so every stream starts empty.
// A full output register that is not taken stalls the decode stage and the input.
`default_nettype none

module stream_message_deframer
   import smd_pkg::*;
#(
   parameter int NUM_STREAMS = 16
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [3:0] stream, [11:4] data_byte, [15:12] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [3:0] out_stream, [11:4] out_byte,
                                         // [27:12] message_length, [31:28] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // [15:0] max_message_bytes
);

   localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   state_type            mem [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] valid_ff;

   logic [15:0]      max_bytes_ff;
   logic             s1_valid_ff;
   logic             s1_in_range_ff;
   logic [3:0]       s1_stream_ff;
   logic [7:0]       s1_byte_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   state_type        rd_ff;
   logic             rd_valid_ff;

   logic             rsp_valid_ff;
   logic [3:0]       rsp_stream_ff;
   kind_type         rsp_kind_ff;
   logic [7:0]       rsp_byte_ff;
   logic [15:0]      rsp_length_ff;

   logic [3:0]       req_stream;
   logic [IDX_W+3:0] req_idx_ext;
   logic [IDX_W-1:0] req_idx;
   logic             req_in_range;
   logic             req_accept;
   logic             fwd;
   state_type        cur_state;
   state_type        upd_state;
   result_type       upd_result;
   logic             res_valid;
   logic             s1_go;
   logic             wr_en;
   logic             s1_valid_in;

   assign req_stream   = req_tdata[3:0];
   assign req_idx_ext  = {{IDX_W{1'b0}}, req_stream};
   assign req_idx      = req_idx_ext[IDX_W-1:0];
   assign req_in_range = ({28'd0, req_stream} < 32'(NUM_STREAMS));

   assign cur_state = rd_valid_ff ? rd_ff : '0;

   smd_update u_update (
      .cur_state (cur_state),
      .data_byte (s1_byte_ff),
      .max_bytes (max_bytes_ff),
      .nxt_state (upd_state),
      .result    (upd_result)
   );

   assign res_valid   = upd_result.valid && s1_in_range_ff;
   assign s1_go       = s1_valid_ff && (!res_valid || !rsp_valid_ff || rsp_tready);
   assign wr_en       = s1_go && s1_in_range_ff;
   assign req_tready  = !reset && (!s1_valid_ff || s1_go);
   assign req_accept  = req_tvalid && req_tready;
   assign fwd         = wr_en && (s1_idx_ff == req_idx);
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);
   assign csr_ready   = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_INIT;
      end else if (csr_valid && csr_ready) begin
         max_bytes_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_idx_ff] <= upd_state;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= fwd ? upd_state : mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[s1_idx_ff] <= 1'b1;
         end
         if (req_accept) begin
            rd_valid_ff <= fwd || valid_ff[req_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_in_range_ff <= req_in_range;
         s1_stream_ff   <= req_stream;
         s1_byte_ff     <= req_tdata[11:4];
         s1_idx_ff      <= req_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_go && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && res_valid) begin
         rsp_stream_ff <= s1_stream_ff;
         rsp_kind_ff   <= upd_result.kind;
         rsp_byte_ff   <= upd_result.out_byte;
         rsp_length_ff <= upd_result.message_length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_length_ff, rsp_byte_ff, rsp_stream_ff};
   assign rsp_tuser  = rsp_kind_ff;

   a_end_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_END) |-> rsp_length_ff != 16'd0)
      else $error("end result with zero length");

   a_byte_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff != KIND_DATA) |-> rsp_byte_ff == 8'd0)
      else $error("nonzero byte on a non-data result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_stream_ff) && $stable(s1_byte_ff))
      else $error("decode stage lost a stalled transaction");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |-> !req_tready)
      else $error("input accepted while decode stage is stalled");

endmodule

`default_nettype wire
